/* sv/assert_macros.svh */
// Assertion macros shared by the LRU cache manager RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SBLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SBLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/sblc_pkg.sv */
// Package for the byte-budget LRU cache manager.
// Holds the field widths, event codes and state encoding; no dependencies.
package sblc_pkg;

    localparam int ID_W       = 5;
    localparam int LINK_W     = 6;
    localparam int KIND_W     = 3;
    localparam int BUDGET_W   = 40;
    localparam int IN_BYTES_W = 36;
    localparam int LOADS_W    = 32;
    localparam int WIDE_W     = 49;

    localparam logic [LINK_W-1:0]   LINK_NIL     = '1;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 40'd536870912;

    localparam logic [KIND_W-1:0] KIND_EVICTED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HIT       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOADED    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NO_SPACE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REGISTERED = 3'd4;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ONE    = 10'b0000000010,
        S_REG_RD = 10'b0000000100,
        S_HIT_UL = 10'b0000001000,
        S_HIT_AP = 10'b0000010000,
        S_LD_RD  = 10'b0000100000,
        S_EV_CHK = 10'b0001000000,
        S_EV_RD  = 10'b0010000000,
        S_LOAD   = 10'b0100000000,
        S_SPARE  = 10'b1000000000
    } t_state;

endpackage

/* sv/sblc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sblc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/size_budget_lru_cache_manager.sv */
// Top level of the byte-budget LRU cache manager.
// Uses sblc_pkg, sblc_ram and assert_macros.svh.
//
// Items enter on a command channel: an item transfers at a rising edge with
// start high and busy low. Mode 0 records an entry's size, mode 1 requests
// residency of an entry. Every item gives one or more results, each shown
// for exactly one cycle with o_event_valid high; o_final_event marks the
// last result of an item. The receiver cannot stall the block.
// The budget register is written on its own channel (i_cfg_valid with
// o_cfg_ready, which is always high); the user must write it only while the
// block is idle, as the block itself does not enforce this. A load reads the
// entry's size, then evicts the oldest entry while the budget would be
// exceeded, and is refused when nothing is left to evict or the victim was
// loaded in this batch. Each eviction step waits on one registered read of the
// memories. A result is registered and appears in the cycle after its step.
// Synchronous reset empties the list, clears the byte count, batch stamp
// and load count, and sets the budget to 512 MiB. Entry sizes, stamps and
// links are held in memories that reset does not clear.
module size_budget_lru_cache_manager #(
    parameter int NUM_ENTRIES = 32,
    parameter int STAMP_BITS  = 16,
    parameter int SIZE_BITS   = 36
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_mode,
    input  logic [sblc_pkg::ID_W-1:0]          i_entry_id,
    input  logic [sblc_pkg::IN_BYTES_W-1:0]    i_entry_bytes,
    input  logic                               i_ends_batch,
    output logic                               o_event_valid,
    output logic [sblc_pkg::KIND_W-1:0]        o_event_kind,
    output logic [sblc_pkg::ID_W-1:0]          o_event_entry,
    output logic [sblc_pkg::BUDGET_W-1:0]      o_bytes_in_use,
    output logic [sblc_pkg::LOADS_W-1:0]       o_load_total,
    output logic                               o_final_event,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sblc_pkg::BUDGET_W-1:0]      i_cfg_data
);
    import sblc_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = $clog2(NUM_ENTRIES);
    localparam logic [LINK_W-1:0] LINK_N = LINK_W'(NUM_ENTRIES);

    t_state                  r_state, n_state;
    logic                    r_mode, n_mode;
    logic [ID_W-1:0]         r_id, n_id;
    logic [SIZE_BITS-1:0]    r_bytes, n_bytes;
    logic                    r_ends, n_ends;
    logic [SIZE_BITS-1:0]    r_need, n_need;
    logic [KIND_W-1:0]       r_pend, n_pend;
    logic [BUDGET_W-1:0]     r_budget;
    logic [BUDGET_W-1:0]     r_used, n_used;
    logic [STAMP_BITS-1:0]   r_batch, n_batch;
    logic [LOADS_W-1:0]      r_loads, n_loads;
    logic [LINK_W-1:0]       r_oldest, n_oldest, r_newest, n_newest;
    logic [NUM_ENTRIES-1:0]  r_resident, n_resident;

    logic                    r_ev_valid, n_ev_valid;
    logic [KIND_W-1:0]       r_ev_kind, n_ev_kind;
    logic [ID_W-1:0]         r_ev_entry, n_ev_entry;
    logic [BUDGET_W-1:0]     r_ev_bytes;
    logic [LOADS_W-1:0]      r_ev_loads;
    logic                    r_ev_final, n_ev_final;

    logic                    size_we, stamp_we, older_we, newer_we;
    logic [AW-1:0]           size_wa, older_wa, newer_wa, raddr;
    logic [SIZE_BITS-1:0]    size_wd, size_q;
    logic [STAMP_BITS-1:0]   stamp_q;
    logic [LINK_W-1:0]       older_wd, newer_wd, older_q, newer_q;

    logic                    accept;
    logic [LINK_W-1:0]       in_id6, id6, link_o, link_n, ev_n;
    logic [AW-1:0]           in_addr, id_addr, oldest_addr, newest_addr;
    logic [WIDE_W-1:0]       used_plus;
    logic                    over;
    logic [BUDGET_W-1:0]     size_q40, need40;
    logic [WIDE_W-1:0]       in_bytes_wide;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign in_id6      = LINK_W'(i_entry_id);
    assign id6         = LINK_W'(r_id);
    assign in_addr     = in_id6[AW-1:0];
    assign id_addr     = id6[AW-1:0];
    assign oldest_addr = r_oldest[AW-1:0];
    assign newest_addr = r_newest[AW-1:0];
    assign raddr       = (r_state == S_IDLE) ? in_addr : oldest_addr;

    assign in_bytes_wide = WIDE_W'(i_entry_bytes);
    assign size_q40      = BUDGET_W'(size_q);
    assign need40        = BUDGET_W'(r_need);
    assign used_plus     = WIDE_W'(r_used) + WIDE_W'(r_need);
    assign over          = used_plus > WIDE_W'(r_budget);

    assign link_o = (id6 == r_oldest) ? LINK_NIL : older_q;
    assign link_n = (id6 == r_newest) ? LINK_NIL : newer_q;
    assign ev_n   = (r_oldest == r_newest) ? LINK_NIL : newer_q;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_id       = r_id;
        n_bytes    = r_bytes;
        n_ends     = r_ends;
        n_need     = r_need;
        n_pend     = r_pend;
        n_used     = r_used;
        n_batch    = r_batch;
        n_loads    = r_loads;
        n_oldest   = r_oldest;
        n_newest   = r_newest;
        n_resident = r_resident;
        n_ev_valid = 1'b0;
        n_ev_kind  = r_pend;
        n_ev_entry = r_id;
        n_ev_final = 1'b0;
        size_we    = 1'b0;
        size_wa    = id_addr;
        size_wd    = r_bytes;
        stamp_we   = 1'b0;
        older_we   = 1'b0;
        older_wa   = id_addr;
        older_wd   = r_newest;
        newer_we   = 1'b0;
        newer_wa   = newest_addr;
        newer_wd   = id6;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode  = i_mode;
                    n_id    = i_entry_id;
                    n_bytes = in_bytes_wide[SIZE_BITS-1:0];
                    n_ends  = i_ends_batch;
                    if (in_id6 >= LINK_N) begin
                        n_pend  = KIND_NO_SPACE;
                        n_state = S_ONE;
                    end else if (!i_mode) begin
                        if (r_resident[in_addr]) begin
                            n_state = S_REG_RD;
                        end else begin
                            size_we = 1'b1;
                            size_wa = in_addr;
                            size_wd = in_bytes_wide[SIZE_BITS-1:0];
                            n_pend  = KIND_REGISTERED;
                            n_state = S_ONE;
                        end
                    end else if (r_resident[in_addr]) begin
                        if (in_id6 == r_newest) begin
                            n_pend  = KIND_HIT;
                            n_state = S_ONE;
                        end else begin
                            n_state = S_HIT_UL;
                        end
                    end else begin
                        n_state = S_LD_RD;
                    end
                end
            end
            S_ONE: begin
                n_ev_valid = 1'b1;
                n_ev_final = 1'b1;
                n_state    = S_IDLE;
            end
            S_REG_RD, S_HIT_UL: begin
                if (link_o < LINK_N) begin
                    newer_we = 1'b1;
                    newer_wa = link_o[AW-1:0];
                    newer_wd = link_n;
                end else begin
                    n_oldest = link_n;
                end
                if (link_n < LINK_N) begin
                    older_we = 1'b1;
                    older_wa = link_n[AW-1:0];
                    older_wd = link_o;
                end else begin
                    n_newest = link_o;
                end
                if (r_state == S_REG_RD) begin
                    n_used              = r_used - size_q40;
                    n_resident[id_addr] = 1'b0;
                    size_we             = 1'b1;
                    n_ev_valid          = 1'b1;
                    n_ev_final          = 1'b1;
                    n_ev_kind           = KIND_REGISTERED;
                    n_state             = S_IDLE;
                end else begin
                    n_state = S_HIT_AP;
                end
            end
            S_HIT_AP, S_LOAD: begin
                older_we = 1'b1;
                if (r_newest < LINK_N) begin
                    newer_we = 1'b1;
                end else begin
                    n_oldest = id6;
                end
                n_newest   = id6;
                n_ev_valid = 1'b1;
                n_ev_final = 1'b1;
                n_ev_kind  = KIND_HIT;
                if (r_state == S_LOAD) begin
                    stamp_we            = 1'b1;
                    n_resident[id_addr] = 1'b1;
                    n_used              = r_used + need40;
                    n_loads             = r_loads + 1'b1;
                    n_ev_kind           = KIND_LOADED;
                end
                n_state = S_IDLE;
            end
            S_LD_RD: begin
                n_need  = size_q;
                n_state = S_EV_CHK;
            end
            S_EV_CHK: begin
                if (!over) begin
                    n_state = S_LOAD;
                end else if (r_oldest >= LINK_N) begin
                    n_pend  = KIND_NO_SPACE;
                    n_state = S_ONE;
                end else begin
                    n_state = S_EV_RD;
                end
            end
            S_EV_RD: begin
                if (stamp_q == r_batch) begin
                    n_pend  = KIND_NO_SPACE;
                    n_state = S_ONE;
                end else begin
                    n_oldest = ev_n;
                    if (ev_n >= LINK_N) begin
                        n_newest = LINK_NIL;
                    end
                    n_resident[oldest_addr] = 1'b0;
                    n_used     = r_used - size_q40;
                    n_ev_valid = 1'b1;
                    n_ev_kind  = KIND_EVICTED;
                    n_ev_entry = r_oldest[ID_W-1:0];
                    n_state    = S_EV_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_ev_final && r_mode && r_ends) begin
            n_batch = r_batch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_budget   <= BUDGET_RESET;
            r_used     <= '0;
            r_batch    <= '0;
            r_loads    <= '0;
            r_oldest   <= LINK_NIL;
            r_newest   <= LINK_NIL;
            r_resident <= '0;
            r_ev_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_batch    <= n_batch;
            r_loads    <= n_loads;
            r_oldest   <= n_oldest;
            r_newest   <= n_newest;
            r_resident <= n_resident;
            r_ev_valid <= n_ev_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_budget <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_id       <= n_id;
        r_bytes    <= n_bytes;
        r_ends     <= n_ends;
        r_need     <= n_need;
        r_pend     <= n_pend;
        r_ev_kind  <= n_ev_kind;
        r_ev_entry <= n_ev_entry;
        r_ev_bytes <= n_used;
        r_ev_loads <= n_loads;
        r_ev_final <= n_ev_final;
    end

    assign o_event_valid  = r_ev_valid;
    assign o_event_kind   = r_ev_kind;
    assign o_event_entry  = r_ev_entry;
    assign o_bytes_in_use = r_ev_bytes;
    assign o_load_total   = r_ev_loads;
    assign o_final_event  = r_ev_final;

    sblc_ram #(.WIDTH(SIZE_BITS), .DEPTH(NUM_ENTRIES)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (size_wa),
        .i_wdata (size_wd),
        .i_raddr (raddr),
        .o_rdata (size_q)
    );

    sblc_ram #(.WIDTH(STAMP_BITS), .DEPTH(NUM_ENTRIES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (id_addr),
        .i_wdata (r_batch),
        .i_raddr (raddr),
        .o_rdata (stamp_q)
    );

    sblc_ram #(.WIDTH(LINK_W), .DEPTH(NUM_ENTRIES)) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (older_we),
        .i_waddr (older_wa),
        .i_wdata (older_wd),
        .i_raddr (raddr),
        .o_rdata (older_q)
    );

    sblc_ram #(.WIDTH(LINK_W), .DEPTH(NUM_ENTRIES)) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (newer_we),
        .i_waddr (newer_wa),
        .i_wdata (newer_wd),
        .i_raddr (raddr),
        .o_rdata (newer_q)
    );

    `SBLC_ASSERT_IMP(a_evict_not_final, i_clk, i_rst_n,
        r_ev_valid && (r_ev_kind == KIND_EVICTED), !r_ev_final)
    `SBLC_ASSERT_IMP(a_ends_agree, i_clk, i_rst_n,
        1'b1, (r_oldest == LINK_NIL) == (r_newest == LINK_NIL))
    `SBLC_ASSERT_NXT(a_load_reports, i_clk, i_rst_n,
        r_state == S_LOAD, r_ev_valid && r_ev_final && (r_ev_kind == KIND_LOADED))
    `SBLC_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
endmodule

/* tb/lru_residency_checker.sv */
`timescale 1ns / 1ps
// Checker for the byte-budget LRU cache manager: watches the command, result
// and budget channels, predicts every result and compares it. Uses sblc_pkg.
module lru_residency_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                i_mode,
    input  logic [sblc_pkg::ID_W-1:0]           i_entry_id,
    input  logic [sblc_pkg::IN_BYTES_W-1:0]     i_entry_bytes,
    input  logic                                i_ends_batch,
    input  logic                                o_event_valid,
    input  logic [sblc_pkg::KIND_W-1:0]         o_event_kind,
    input  logic [sblc_pkg::ID_W-1:0]           o_event_entry,
    input  logic [sblc_pkg::BUDGET_W-1:0]       o_bytes_in_use,
    input  logic [sblc_pkg::LOADS_W-1:0]        o_load_total,
    input  logic                                o_final_event,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [sblc_pkg::BUDGET_W-1:0]       i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import sblc_pkg::*;

    localparam int NUM_ENTRIES = 32;
    localparam logic MODE_REQUEST = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     entry;
        logic [BUDGET_W-1:0] in_use;
        logic [LOADS_W-1:0]  loads;
        logic                last;
    } t_event;

    t_event              expected_events[$];
    logic [35:0]         size_of[NUM_ENTRIES];
    bit                  resident[NUM_ENTRIES];
    logic [15:0]         stamp_of[NUM_ENTRIES];
    logic [LINK_W-1:0]   older[NUM_ENTRIES];
    logic [LINK_W-1:0]   newer[NUM_ENTRIES];
    logic [LINK_W-1:0]   oldest;
    logic [LINK_W-1:0]   newest;
    logic [BUDGET_W-1:0] in_use;
    logic [BUDGET_W-1:0] budget;
    logic [15:0]         batch;
    logic [LOADS_W-1:0]  loads;
    int                  fails;

    assign o_fail_count = fails;
    assign o_pending = expected_events.size();

    initial fails = 0;

    function automatic void unlink(input int e);
        logic [LINK_W-1:0] o;
        logic [LINK_W-1:0] n;
        o = older[e];
        n = newer[e];
        if (int'(o) < NUM_ENTRIES) newer[o] = n; else oldest = n;
        if (int'(n) < NUM_ENTRIES) older[n] = o; else newest = o;
        older[e] = LINK_NIL;
        newer[e] = LINK_NIL;
    endfunction

    function automatic void append(input int e);
        older[e] = newest;
        newer[e] = LINK_NIL;
        if (int'(newest) < NUM_ENTRIES) newer[newest] = LINK_W'(e); else oldest = LINK_W'(e);
        newest = LINK_W'(e);
    endfunction

    function automatic void push_event(input logic [KIND_W-1:0] kind, input int e);
        t_event ev;
        ev.kind = kind;
        ev.entry = ID_W'(e);
        ev.in_use = in_use;
        ev.loads = loads;
        ev.last = 1'b0;
        expected_events.insert(expected_events.size(), ev);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("Mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
        fails++;
    endtask

    task automatic predict_item();
        int id;
        int v;
        bit failed;
        id = int'(i_entry_id);
        if (i_mode != MODE_REQUEST) begin
            if (resident[id]) begin
                unlink(id);
                in_use = in_use - BUDGET_W'(size_of[id]);
                resident[id] = 0;
            end
            size_of[id] = i_entry_bytes;
            push_event(KIND_REGISTERED, id);
        end else if (resident[id]) begin
            if (int'(newest) != id) begin
                unlink(id);
                append(id);
            end
            push_event(KIND_HIT, id);
        end else begin
            failed = 0;
            while ({24'd0, in_use} + {28'd0, size_of[id]} > {24'd0, budget}) begin
                v = int'(oldest);
                if (v >= NUM_ENTRIES || stamp_of[v] == batch) begin
                    failed = 1;
                    break;
                end
                unlink(v);
                resident[v] = 0;
                in_use = in_use - BUDGET_W'(size_of[v]);
                push_event(KIND_EVICTED, v);
            end
            if (failed) begin
                push_event(KIND_NO_SPACE, id);
            end else begin
                resident[id] = 1;
                stamp_of[id] = batch;
                in_use = in_use + BUDGET_W'(size_of[id]);
                loads = loads + 1'b1;
                append(id);
                push_event(KIND_LOADED, id);
            end
        end
        if (i_mode == MODE_REQUEST && i_ends_batch) batch = batch + 1'b1;
        expected_events[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_event want;
        if (!i_rst_n) begin
            expected_events.delete();
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                resident[i] = 0;
                older[i] = LINK_NIL;
                newer[i] = LINK_NIL;
            end
            oldest = LINK_NIL;
            newest = LINK_NIL;
            in_use = '0;
            budget = BUDGET_RESET;
            batch = '0;
            loads = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) budget = i_cfg_data;
            if (o_event_valid) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected result kind", 64'(o_event_kind), 64'(0));
                end else begin
                    want = expected_events.pop_front();
                    if (o_event_kind !== want.kind)
                        report_mismatch("event_kind", 64'(o_event_kind), 64'(want.kind));
                    if (o_event_entry !== want.entry)
                        report_mismatch("event_entry", 64'(o_event_entry), 64'(want.entry));
                    if (o_bytes_in_use !== want.in_use)
                        report_mismatch("bytes_in_use", 64'(o_bytes_in_use),
                                        64'(want.in_use));
                    if (o_load_total !== want.loads)
                        report_mismatch("load_total", 64'(o_load_total), 64'(want.loads));
                    if (o_final_event !== want.last)
                        report_mismatch("final_event", 64'(o_final_event), 64'(want.last));
                end
            end
            if (start && !busy) predict_item();
        end
    end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Top of the testbench for the byte-budget LRU cache manager: drives items and
// budget writes, and gives the verdict. Uses sblc_pkg and lru_residency_checker.
module tb;
    import sblc_pkg::*;

    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_REQUEST  = 1'b1;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [35:0] SIZE_MAX = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_mode = 1'b0;
    logic [ID_W-1:0]       i_entry_id = '0;
    logic [IN_BYTES_W-1:0] i_entry_bytes = '0;
    logic                  i_ends_batch = 1'b0;
    logic                  o_event_valid;
    logic [KIND_W-1:0]     o_event_kind;
    logic [ID_W-1:0]       o_event_entry;
    logic [BUDGET_W-1:0]   o_bytes_in_use;
    logic [LOADS_W-1:0]    o_load_total;
    logic                  o_final_event;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [BUDGET_W-1:0]   i_cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    bit                    registered[32];
    logic [BUDGET_W-1:0]   cur_budget = BUDGET_RESET;
    bit                    bursty = 0;

    size_budget_lru_cache_manager DUT (.*);

    lru_residency_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_mode, .i_entry_id, .i_entry_bytes,
        .i_ends_batch, .o_event_valid, .o_event_kind, .o_event_entry,
        .o_bytes_in_use, .o_load_total, .o_final_event, .i_cfg_valid,
        .o_cfg_ready, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic mode, input int id, input logic [35:0] bytes,
                             input logic ends);
        int gap;
        gap = bursty ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_mode = mode;
        i_entry_id = ID_W'(id);
        i_entry_bytes = bytes;
        i_ends_batch = ends;
        start = 1'b1;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        if (mode == MODE_REGISTER) registered[id] = 1;
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_budget(input logic [BUDGET_W-1:0] value);
        wait_idle();
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cur_budget = value;
    endtask

    function automatic logic [35:0] pick_size();
        logic [63:0] lim;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return 36'({$urandom, $urandom});
        if (cur_budget == 0) return 36'($urandom_range(0, 3));
        lim = cur_budget / 3;
        if (lim > SIZE_MAX) lim = SIZE_MAX;
        return 36'({$urandom, $urandom} % (lim + 1));
    endfunction

    task automatic random_items(input int count);
        int id;
        for (int k = 0; k < count; k++) begin
            if (k % 16 == 0) bursty = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 30) begin
                send_item(MODE_REGISTER, $urandom_range(0, 31), pick_size(),
                          1'($urandom));
            end else begin
                do id = $urandom_range(0, 31); while (!registered[id]);
                send_item(MODE_REQUEST, id, 36'({$urandom, $urandom}),
                          $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_item(MODE_REGISTER, 0, '0, 1'b1);
        send_item(MODE_REGISTER, 31, SIZE_MAX, 1'b0);
        for (int i = 1; i <= 5; i++) send_item(MODE_REGISTER, i, 36'd1 << 27, 1'b0);
        for (int i = 1; i <= 4; i++) send_item(MODE_REQUEST, i, '0, 1'b0);
        send_item(MODE_REQUEST, 1, SIZE_MAX, 1'b0);
        send_item(MODE_REQUEST, 4, '0, 1'b0);
        send_item(MODE_REQUEST, 5, '0, 1'b1);
        send_item(MODE_REQUEST, 5, '0, 1'b0);
        send_item(MODE_REQUEST, 31, '0, 1'b1);
        send_item(MODE_REGISTER, 5, 36'd1 << 26, 1'b1);
        send_item(MODE_REQUEST, 0, '0, 1'b1);
        send_item(MODE_REQUEST, 2, '0, 1'b1);
        send_item(MODE_REQUEST, 3, '0, 1'b1);

        // Hold the sender until every expected result has arrived.
        wait_idle();
        send_item(MODE_REQUEST, 31, '0, 1'b0);

        random_items(35);
        set_budget('0);
        send_item(MODE_REQUEST, 0, '0, 1'b1);
        random_items(30);
        set_budget('1);
        send_item(MODE_REQUEST, 31, '0, 1'b1);
        random_items(35);
        set_budget(40'd1 << 20);
        random_items(35);
        set_budget(40'd1000);
        random_items(35);
        set_budget(BUDGET_RESET);
        random_items(35);

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
